@@ hw/rtl/lpd_pkg.sv @@
// Shared types, field layout and constants of the LUT16 distance accumulator.
package lpd_pkg;

  localparam int BLOCK_COUNT_DEFAULT = 512;

  localparam int LANES    = 32;
  localparam int OFFSET_W = 5;
  localparam int DIST_W   = 32;
  localparam int BLK_W    = 9;
  localparam int BYTES_W  = 64;
  localparam int ROW_W    = 2 * BYTES_W;
  localparam int CODE_W   = 4;
  localparam int BYTE_W   = 8;

  // Request tdata layout, lowest bit first.
  localparam int IN_BLK_LSB  = 0;
  localparam int IN_HALF_BIT = IN_BLK_LSB + BLK_W;
  localparam int IN_TBL_LSB  = IN_HALF_BIT + 1;
  localparam int IN_CLO_LSB  = IN_TBL_LSB + BYTES_W;
  localparam int IN_CHI_LSB  = IN_CLO_LSB + BYTES_W;
  localparam int IN_FIELDS_W = IN_CHI_LSB + BYTES_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

  // Result tdata layout, lowest bit first.
  localparam int OUT_DIST_LSB = OFFSET_W;
  localparam int OUT_FIELDS_W = OFFSET_W + DIST_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_CODE = 1'b1
  } mode_e;

  typedef logic [DIST_W-1:0] dist_t;
  typedef dist_t [LANES-1:0] dist_vec_t;

  typedef struct packed {
    logic en;
    logic last;
  } acc_ctrl_t;

  function automatic int addr_width(int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

@@ hw/rtl/lpd_blkmod.sv @@
// Block index reduction modulo the table depth, one register stage.
module lpd_blkmod #(
  parameter int BLOCK_COUNT = lpd_pkg::BLOCK_COUNT_DEFAULT
) (
  input  logic                                          clk_i,
  input  logic                                          en_i,
  input  logic [lpd_pkg::BLK_W-1:0]                     blk_i,
  output logic [lpd_pkg::addr_width(BLOCK_COUNT)-1:0]   addr_o
);
  import lpd_pkg::*;

  localparam int AddrW = addr_width(BLOCK_COUNT);

  logic [BLK_W-1:0] blk_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      blk_q <= blk_i;
    end
  end

  if (BLOCK_COUNT == 1) begin : g_single
    assign addr_o = '0;
  end else if (((BLOCK_COUNT & (BLOCK_COUNT - 1)) == 0) ||
               (BLOCK_COUNT >= (1 << BLK_W))) begin : g_plain
    // Power of two: keep the low bits. Deep table: index is already in range.
    assign addr_o = AddrW'(blk_q);
  end else begin : g_recip
    // Quotient estimate by reciprocal is low by at most one; fix with one subtract.
    localparam int Shift = 18;
    localparam int ProdW = BLK_W + Shift;
    localparam int Recip = (1 << Shift) / BLOCK_COUNT;
    localparam int RemW  = BLK_W + 1;
    localparam int QnW   = 2 * BLK_W + 1;

    logic [ProdW-1:0] prod_q;
    logic [BLK_W-1:0] quo;
    logic [QnW-1:0]   qn;
    logic [RemW-1:0]  rem_raw;
    logic [RemW-1:0]  rem;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        prod_q <= ProdW'(blk_i) * ProdW'(Recip);
      end
    end

    always_comb begin
      quo     = prod_q[Shift +: BLK_W];
      qn      = QnW'(quo) * QnW'(BLOCK_COUNT);
      rem_raw = RemW'(QnW'(blk_q) - qn);
      rem     = (rem_raw >= RemW'(BLOCK_COUNT)) ? rem_raw - RemW'(BLOCK_COUNT) : rem_raw;
    end

    assign addr_o = AddrW'(rem);
  end

endmodule

@@ hw/rtl/lpd_table.sv @@
// Lookup table store: two banks of 64-bit half-rows, synchronous read.
module lpd_table #(
  parameter int BLOCK_COUNT = lpd_pkg::BLOCK_COUNT_DEFAULT
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic                                         wr_half_i,
  input  logic [lpd_pkg::BYTES_W-1:0]                  wdata_i,
  input  logic                                         re_i,
  input  logic [lpd_pkg::addr_width(BLOCK_COUNT)-1:0]  addr_i,
  output logic [lpd_pkg::ROW_W-1:0]                    rdata_o
);
  import lpd_pkg::*;

  logic [BYTES_W-1:0] mem_lo [BLOCK_COUNT];
  logic [BYTES_W-1:0] mem_hi [BLOCK_COUNT];
  logic [ROW_W-1:0]   rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i && !wr_half_i) begin
      mem_lo[addr_i] <= wdata_i;
    end
    if (we_i && wr_half_i) begin
      mem_hi[addr_i] <= wdata_i;
    end
  end

  // Hold the last row while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= {mem_hi[addr_i], mem_lo[addr_i]};
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/lpd_accum.sv @@
// Thirty-two accumulator lanes: nibble lookup, unbias and add.
module lpd_accum (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lpd_pkg::acc_ctrl_t           ctrl_i,
  input  logic [lpd_pkg::ROW_W-1:0]    codes_i,
  input  logic [lpd_pkg::ROW_W-1:0]    row_i,
  output lpd_pkg::dist_vec_t           sums_o
);
  import lpd_pkg::*;

  dist_t acc_q [LANES];

  always_comb begin
    logic [CODE_W-1:0] code;
    logic [BYTE_W-1:0] entry;
    for (int i = 0; i < LANES; i++) begin
      if (i < LANES / 2) begin
        code = codes_i[BYTE_W * i +: CODE_W];
      end else begin
        code = codes_i[BYTE_W * (i - LANES / 2) + CODE_W +: CODE_W];
      end
      entry = row_i[{code, 3'b000} +: BYTE_W];
      // entry - 128 as a signed byte is the entry with its top bit flipped
      sums_o[i] = acc_q[i] + {{(DIST_W - BYTE_W + 1){~entry[BYTE_W-1]}}, entry[BYTE_W-2:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LANES; i++) begin
        acc_q[i] <= '0;
      end
    end else if (ctrl_i.en) begin
      for (int i = 0; i < LANES; i++) begin
        acc_q[i] <= ctrl_i.last ? '0 : sums_o[i];
      end
    end
  end

endmodule

@@ hw/rtl/lpd_outbuf.sv @@
// Result buffer: holds one group's 32 distances and shifts them out in order.
module lpd_outbuf (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             load_i,
  input  lpd_pkg::dist_vec_t               sums_i,
  input  logic                             narrow_i,
  input  logic                             ready_i,
  output logic                             valid_o,
  output logic [lpd_pkg::OUT_TDATA_W-1:0]  tdata_o,
  output logic                             tlast_o
);
  import lpd_pkg::*;

  dist_vec_t           buf_q;
  logic                valid_q;
  logic [OFFSET_W-1:0] cnt_q;
  dist_t               dist_sel;
  logic                beat;

  assign beat = valid_q && ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      cnt_q   <= '0;
    end else if (beat) begin
      cnt_q <= cnt_q + OFFSET_W'(1);
      if (&cnt_q) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q <= sums_i;
    end else if (beat) begin
      buf_q <= {DIST_W'(0), buf_q[LANES-1:1]};
    end
  end

  assign dist_sel = narrow_i ? {{(DIST_W / 2){buf_q[0][DIST_W/2-1]}}, buf_q[0][DIST_W/2-1:0]}
                             : buf_q[0];
  assign valid_o = valid_q;
  assign tdata_o = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), dist_sel, cnt_q};
  assign tlast_o = &cnt_q;

endmodule

@@ hw/rtl/lut16_pq_distance_accumulator.sv @@
// Top level of the LUT16 product-quantization distance accumulator.
//
// Streams table loads and code blocks and returns 32 distances per group.
// A load request (tuser = 0) writes eight biased table bytes of one block; a
// code request (tuser = 1) carries 16 code bytes whose low and high nibbles
// index the block's 16-entry table for datapoints i and i+16. Each lane adds
// the looked-up byte minus 128. The request with tlast set closes the group:
// its 32 sums leave in datapoint order, one result per cycle while the result
// side accepts them, and the lanes restart at zero. Requests are taken one per
// cycle; a request passes three register stages (capture with block-index
// reduction, table read, lane add), and the first result of a closing request
// is offered once it has left the add stage. Only a closing request waits: it
// holds in the add stage, and stalls the input, until the previous group's 32
// results have all drained from the result buffer. The table sits in two banks
// of BLOCK_COUNT x 64 bits that are read and written in the same stage in
// request order, so a code request right behind a load of its block sees the
// new bytes. Table entries hold nothing until loaded; there is no clearing
// pass. block_index is taken modulo BLOCK_COUNT. narrow_result = 1 returns each
// sum wrapped to signed 16 bits; write it only while no request is in flight.
module lut16_pq_distance_accumulator #(
  parameter int BLOCK_COUNT = lpd_pkg::BLOCK_COUNT_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request channel
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // block_index[8:0], half[9], table_bytes[73:10], code_bytes_lo[137:74],
  // code_bytes_hi[201:138], zero fill
  input  logic [lpd_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // mode[0]
  input  logic [0:0]                      s_axis_tuser_i,
  // last_block
  input  logic                            s_axis_tlast_i,
  // result channel
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // datapoint_offset[4:0], distance[36:5], zero fill
  output logic [lpd_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // last
  output logic                            m_axis_tlast_o,
  // narrow_result register
  input  logic                            cfg_we_i,
  input  logic                            cfg_wdata_i
);
  import lpd_pkg::*;

  localparam int AddrW = addr_width(BLOCK_COUNT);

  logic narrow_q;

  logic advance;
  logic stall;
  logic in_fire;

  // capture stage
  logic               p1_valid_q;
  mode_e              p1_mode_q;
  logic               p1_half_q;
  logic               p1_last_q;
  logic [BYTES_W-1:0] p1_tbl_q;
  logic [ROW_W-1:0]   p1_codes_q;

  // table read stage
  logic               p2_valid_q;
  mode_e              p2_mode_q;
  logic               p2_last_q;
  logic [ROW_W-1:0]   p2_codes_q;

  logic [AddrW-1:0]   tbl_addr;
  logic [ROW_W-1:0]   tbl_row;
  acc_ctrl_t          acc_ctrl;
  dist_vec_t          sums;
  logic               out_busy;

  // Hold everything while a closing request waits for the result buffer.
  assign stall   = p2_valid_q && (p2_mode_q == MODE_CODE) && p2_last_q && out_busy;
  assign advance = !stall;
  assign in_fire = s_axis_tvalid_i && advance;

  assign s_axis_tready_o = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      narrow_q <= 1'b0;
    end else if (cfg_we_i) begin
      narrow_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
    end else if (advance) begin
      p1_valid_q <= s_axis_tvalid_i;
      p2_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      p1_mode_q  <= mode_e'(s_axis_tuser_i[0]);
      p1_half_q  <= s_axis_tdata_i[IN_HALF_BIT];
      p1_last_q  <= s_axis_tlast_i;
      p1_tbl_q   <= s_axis_tdata_i[IN_TBL_LSB +: BYTES_W];
      p1_codes_q <= s_axis_tdata_i[IN_CLO_LSB +: ROW_W];
    end
    if (advance && p1_valid_q) begin
      p2_mode_q  <= p1_mode_q;
      p2_last_q  <= p1_last_q;
      p2_codes_q <= p1_codes_q;
    end
  end

  lpd_blkmod #(
    .BLOCK_COUNT(BLOCK_COUNT)
  ) u_blkmod (
    .clk_i (clk_i),
    .en_i  (in_fire),
    .blk_i (s_axis_tdata_i[IN_BLK_LSB +: BLK_W]),
    .addr_o(tbl_addr)
  );

  // Loads write and code blocks read at the same stage, so order is kept.
  lpd_table #(
    .BLOCK_COUNT(BLOCK_COUNT)
  ) u_table (
    .clk_i    (clk_i),
    .we_i     (advance && p1_valid_q && (p1_mode_q == MODE_LOAD)),
    .wr_half_i(p1_half_q),
    .wdata_i  (p1_tbl_q),
    .re_i     (advance && p1_valid_q && (p1_mode_q == MODE_CODE)),
    .addr_i   (tbl_addr),
    .rdata_o  (tbl_row)
  );

  assign acc_ctrl.en   = advance && p2_valid_q && (p2_mode_q == MODE_CODE);
  assign acc_ctrl.last = p2_last_q;

  lpd_accum u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (acc_ctrl),
    .codes_i(p2_codes_q),
    .row_i  (tbl_row),
    .sums_o (sums)
  );

  lpd_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (acc_ctrl.en && acc_ctrl.last),
    .sums_i  (sums),
    .narrow_i(narrow_q),
    .ready_i (m_axis_tready_i),
    .valid_o (out_busy),
    .tdata_o (m_axis_tdata_o),
    .tlast_o (m_axis_tlast_o)
  );

  assign m_axis_tvalid_o = out_busy;

endmodule

@@ hw/rtl/lpd_checker.sv @@
// Port-level checks on the result stream of the distance accumulator.
module lpd_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  input  logic [lpd_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input  logic                            m_axis_tlast_o
);
  import lpd_pkg::*;

  logic [OFFSET_W-1:0] offset;

  assign offset = m_axis_tdata_o[OFFSET_W-1:0];

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

  // tlast marks the final datapoint of the group.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (&offset)))
    else $error("tlast does not match datapoint offset");

  // Within a group, offsets step by one with no gap.
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=>
      m_axis_tvalid_o && (offset == $past(offset) + OFFSET_W'(1)))
    else $error("datapoint offset skipped or group cut short");

  // A group starts at datapoint zero.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> (offset == '0))
    else $error("group did not start at offset zero");

endmodule

bind lut16_pq_distance_accumulator lpd_checker u_lpd_checker (.*);
